@@ rtl/hamming_sec_decoder_assert.svh @@
// Assertion macros used by the Hamming decoder RTL.
`ifndef HAMMING_SEC_DECODER_ASSERT_SVH
`define HAMMING_SEC_DECODER_ASSERT_SVH

`ifndef SYNTH

// Checks that a condition holds at every clock edge outside reset.
`define HSD_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Checks that a condition implies another one in the same cycle.
`define HSD_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that a condition implies another one in the next cycle.
`define HSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define HSD_ASSERT_ALWAYS(label, expr)
`define HSD_ASSERT_IMPLIES(label, ante, cons)
`define HSD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/hsd_pkg.sv @@
// Types, constants and helper functions of the Hamming decoder.
package hsd_pkg;

    localparam int CODE_BITS = 71;
    localparam int LOW_BITS  = 64;
    localparam int HIGH_BITS = CODE_BITS - LOW_BITS;
    localparam int DATA_BITS = 64;
    localparam int SYN_BITS  = 7;
    localparam int SIZE_BITS = 3;

    typedef logic [CODE_BITS-1:0] code_t;
    typedef logic [SYN_BITS-1:0]  syn_t;
    typedef logic [SIZE_BITS-1:0] size_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] data;
        syn_t                 syndrome;
        logic                 corrected;
        logic                 out_of_range;
    } result_t;

    // Codeword length for each size select; the unused code acts as the largest size.
    localparam syn_t LEN_TABLE [2**SIZE_BITS] = '{
        7'd12, 7'd17, 7'd21, 7'd29, 7'd38, 7'd54, 7'd71, 7'd71
    };

    function automatic bit is_pow2(input int pos);
        return (pos != 0) && ((pos & (pos - 1)) == 0);
    endfunction

    // Data bit index that the code bit at a given 1-based position lands in.
    function automatic int data_slot(input int pos);
        int n;
        n = 0;
        for (int q = 1; q < pos; q++)
        begin
            if (!is_pow2(q))
            begin
                n++;
            end
        end
        return n;
    endfunction

endpackage

@@ rtl/hsd_correct.sv @@
// Syndrome, single-bit correction and data extraction of one masked codeword.
module hsd_correct (
    input  hsd_pkg::code_t   code,
    input  hsd_pkg::syn_t    code_len,
    output hsd_pkg::result_t result
);

    hsd_pkg::syn_t  syn;
    hsd_pkg::code_t flip_mask;
    hsd_pkg::code_t fixed;
    logic           in_range;
    logic           flip_en;
    logic [hsd_pkg::DATA_BITS-1:0] data;

    // Each set bit contributes its 1-based position to the syndrome.
    always_comb
    begin
        syn = '0;
        for (int i = 0; i < hsd_pkg::CODE_BITS; i++)
        begin
            if (code[i])
            begin
                syn = syn ^ hsd_pkg::SYN_BITS'(i + 1);
            end
        end
    end

    assign in_range  = (syn <= code_len);
    assign flip_en   = (syn != '0) && in_range;
    assign flip_mask = flip_en ? (hsd_pkg::code_t'(1) << (syn - hsd_pkg::syn_t'(1))) : '0;
    assign fixed     = code ^ flip_mask;

    // Data bits occupy every position that is not a power of two.
    for (genvar p = 1; p <= hsd_pkg::CODE_BITS; p++)
    begin : g_extract
        if (!hsd_pkg::is_pow2(p))
        begin : g_data
            assign data[hsd_pkg::data_slot(p)] = fixed[p-1];
        end
    end

    assign result.data         = data;
    assign result.syndrome     = syn;
    assign result.corrected    = flip_en;
    assign result.out_of_range = (syn != '0) && !in_range;

endmodule

@@ rtl/hamming_sec_decoder.sv @@
// Top level of the Hamming single-error-correcting decoder.
//
// Channel     Direction  Handshake                 Payload
// command     in         start, busy               code_low, code_high
// result      out        done (one-cycle strobe)   data_out, syndrome, corrected,
//                                                  syndrome_out_of_range
// config      in         cfg_valid, cfg_ready      cfg_data (size select)
//
// A codeword is taken in every cycle in which start is high; busy never rises.
// Each codeword is held in the input register, where the decode logic works on
// it, and then in the result register. Done rises at the clock edge after the
// transfer edge, together with the result. The rate, one codeword per cycle,
// is set by the single decode stage, which is fed afresh in every cycle. The
// result is shown for one cycle only, since the receiver has no way to stall
// it. Reset clears the size select to the smallest codeword and drops all
// pending strobes.
module hamming_sec_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [hsd_pkg::LOW_BITS-1:0]    code_low,
    input  logic [hsd_pkg::HIGH_BITS-1:0]   code_high,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hsd_pkg::SIZE_BITS-1:0]   cfg_data,
    output logic                            done,
    output logic [hsd_pkg::DATA_BITS-1:0]   data_out,
    output logic [hsd_pkg::SYN_BITS-1:0]    syndrome,
    output logic                            corrected,
    output logic                            syndrome_out_of_range
);

`include "hamming_sec_decoder_assert.svh"

    hsd_pkg::size_t   size_reg;
    hsd_pkg::syn_t    cur_len;
    hsd_pkg::code_t   code_mask;
    hsd_pkg::code_t   code_in;
    hsd_pkg::code_t   code_reg;
    hsd_pkg::syn_t    len_reg;
    logic             stage_valid_reg;
    hsd_pkg::result_t decode;
    hsd_pkg::result_t result_reg;
    logic             done_reg;

    // The decoder never stalls and always takes a configuration write.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_reg <= cfg_data;
        end
    end

    // Code bits past the configured length are zeroed on capture, so the
    // decode stage sees only the live codeword.
    assign cur_len = hsd_pkg::LEN_TABLE[size_reg];

    always_comb
    begin
        for (int i = 0; i < hsd_pkg::CODE_BITS; i++)
        begin
            code_mask[i] = (hsd_pkg::SYN_BITS'(i) < cur_len);
        end
    end

    assign code_in = {code_high, code_low} & code_mask;

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            code_reg <= code_in;
            len_reg  <= cur_len;
        end
    end

    hsd_correct u_correct (
        .code     (code_reg),
        .code_len (len_reg),
        .result   (decode)
    );

    // Result register stage: the strobe lasts one cycle per codeword.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_valid_reg)
        begin
            result_reg <= decode;
        end
    end

    assign done                  = done_reg;
    assign data_out              = result_reg.data;
    assign syndrome              = result_reg.syndrome;
    assign corrected             = result_reg.corrected;
    assign syndrome_out_of_range = result_reg.out_of_range;

    // A captured codeword always yields exactly one result in the next cycle.
    `HSD_ASSERT_NEXT(a_stage_to_done, stage_valid_reg, done_reg)
    // A result strobe is never shown without a codeword in the decode stage before it.
    `HSD_ASSERT_NEXT(a_no_stray_done, !stage_valid_reg, !done_reg)
    // A correction and an out-of-range syndrome exclude each other.
    `HSD_ASSERT_IMPLIES(a_flag_exclusive, done_reg, !(corrected && syndrome_out_of_range))
    // Either flag needs a nonzero syndrome.
    `HSD_ASSERT_IMPLIES(a_flag_needs_syn, done_reg && (corrected || syndrome_out_of_range),
        syndrome != '0)

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the Hamming single-error-correcting decoder.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // The block answers a transfer through its input and result registers. The drain
    // pause follows the last result, before a size change or the end of the run.
    localparam int DRAIN_CYCLES  = 6;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 105;
    localparam int PRINT_LIMIT   = 100;

    localparam hsd_pkg::result_t NO_ERROR = '0;

    // One row of the directed stimulus. Where checked_by_hand is set, the
    // expected result is written into the row. Otherwise the predictor
    // supplies it.
    typedef struct {
        hsd_pkg::size_t   sel;
        logic [63:0]      lo;
        logic [6:0]       hi;
        bit               checked_by_hand;
        hsd_pkg::result_t want;
    } stim_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    logic [hsd_pkg::LOW_BITS-1:0]        code_low;
    logic [hsd_pkg::HIGH_BITS-1:0]       code_high;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [hsd_pkg::SIZE_BITS-1:0]       cfg_data;
    logic                                done;
    logic [hsd_pkg::DATA_BITS-1:0]       data_out;
    logic [hsd_pkg::SYN_BITS-1:0]        syndrome;
    logic                                corrected;
    logic                                syndrome_out_of_range;

    // These travel with start. They are driven by nonblocking assignment, so
    // the monitor sees the values that belong to the transfer it accepts.
    bit                                  row_checked_by_hand;
    hsd_pkg::result_t                    row_want;

    // Size select as the testbench believes the block holds it. It is updated
    // by the monitor on each configuration transfer.
    hsd_pkg::size_t                      model_sel;
    hsd_pkg::result_t                    pending_decodes[$];
    int                                  mismatch_count;

    // Directed part: the smallest and largest codewords, errors on the first
    // and last positions and on check bits, syndromes past the codeword end,
    // and bits above the codeword that have to be ignored. It also covers the
    // unused size select, which has to act like the 64-bit size.
    stim_row_t directed_rows [21] = '{
        '{3'd0, 64'h0, 7'h00, 1'b1, NO_ERROR},
        '{3'd0, 64'h1, 7'h00, 1'b1, '{64'h0, 7'd1, 1'b1, 1'b0}},
        '{3'd0, 64'h800, 7'h00, 1'b1, '{64'h0, 7'd12, 1'b1, 1'b0}},
        '{3'd0, 64'hC0, 7'h00, 1'b1, '{64'h8, 7'd15, 1'b0, 1'b1}},
        '{3'd0, 64'h0, 7'h7F, 1'b1, NO_ERROR},
        '{3'd0, 64'hFFFF_FFFF_FFFF_F000, 7'h7F, 1'b1, NO_ERROR},
        '{3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 7'h7F, 1'b0, NO_ERROR},
        '{3'd1, 64'h0123_4567_89AB_CDEF, 7'h2A, 1'b0, NO_ERROR},
        '{3'd2, 64'hFEDC_BA98_7654_3210, 7'h15, 1'b0, NO_ERROR},
        '{3'd3, 64'h2000_0000, 7'h00, 1'b1, NO_ERROR},
        '{3'd3, 64'h1000_0002, 7'h00, 1'b0, NO_ERROR},
        '{3'd4, 64'hAAAA_AAAA_AAAA_AAAA, 7'h55, 1'b0, NO_ERROR},
        '{3'd5, 64'h8000_0000_0000_0000, 7'h00, 1'b1, NO_ERROR},
        '{3'd5, 64'h5555_5555_5555_5555, 7'h2A, 1'b0, NO_ERROR},
        '{3'd6, 64'h0, 7'h00, 1'b1, NO_ERROR},
        '{3'd6, 64'h8000_0000_0000_0000, 7'h00, 1'b1, '{64'h0, 7'd64, 1'b1, 1'b0}},
        '{3'd6, 64'h0, 7'h40, 1'b1, '{64'h0, 7'd71, 1'b1, 1'b0}},
        '{3'd6, 64'hC000_0000_0000_0000, 7'h00, 1'b0, NO_ERROR},
        '{3'd6, 64'hFFFF_FFFF_FFFF_FFFF, 7'h7F, 1'b0, NO_ERROR},
        '{3'd7, 64'h0, 7'h20, 1'b1, '{64'h0, 7'd70, 1'b1, 1'b0}},
        '{3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 7'h7F, 1'b0, NO_ERROR}
    };

    hamming_sec_decoder u_dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .start                 (start),
        .busy                  (busy),
        .code_low              (code_low),
        .code_high             (code_high),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_data              (cfg_data),
        .done                  (done),
        .data_out              (data_out),
        .syndrome              (syndrome),
        .corrected             (corrected),
        .syndrome_out_of_range (syndrome_out_of_range)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Codeword length for a size select. The unused select value takes the
    // largest size, and no length goes past the 71 bits that the ports carry.
    function automatic int code_length(input hsd_pkg::size_t sel);
        int len;
        case (sel)
            3'd0:    len = 12;
            3'd1:    len = 17;
            3'd2:    len = 21;
            3'd3:    len = 29;
            3'd4:    len = 38;
            3'd5:    len = 54;
            default: len = 71;
        endcase
        if (len > hsd_pkg::CODE_BITS)
        begin
            len = hsd_pkg::CODE_BITS;
        end
        return len;
    endfunction

    // Predicts the result for one codeword. The syndrome is the XOR of the
    // positions of all set bits inside the codeword. If the syndrome lands
    // inside the codeword, that bit is flipped. The data bits are then packed
    // from every position that is not a power of two.
    function automatic hsd_pkg::result_t decode_codeword(input hsd_pkg::size_t sel,
                                                         input logic [63:0] lo,
                                                         input logic [6:0] hi);
        logic [70:0]      word;
        logic [6:0]       syn;
        int               len;
        int               slot;
        hsd_pkg::result_t res;
        word = {hi, lo};
        len  = code_length(sel);
        syn  = '0;
        res  = '0;
        for (int p = 1; p <= len; p++)
        begin
            if (word[p-1])
            begin
                syn ^= 7'(p);
            end
        end
        res.syndrome = syn;
        if (syn != 0)
        begin
            if (int'(syn) > len)
            begin
                res.out_of_range = 1'b1;
            end
            else
            begin
                word[syn-1]   = ~word[syn-1];
                res.corrected = 1'b1;
            end
        end
        slot = 0;
        for (int p = 1; p <= len; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                res.data[slot] = word[p-1];
                slot++;
            end
        end
        return res;
    endfunction

    // Builds a random stimulus word. Most are proper codewords that carry
    // random data, left clean or given one flipped bit. Some get two flips,
    // and the rest are plain noise. Bits above the codeword are often filled
    // with junk that the block must ignore.
    function automatic logic [70:0] encode_random_word(input hsd_pkg::size_t sel);
        logic [70:0] word;
        logic [63:0] payload;
        logic [6:0]  check;
        int          len;
        int          slot;
        int          kind;
        len  = code_length(sel);
        kind = $urandom_range(0, 9);
        word = '0;
        if (kind >= 8)
        begin
            word[31:0]  = $urandom;
            word[63:32] = $urandom;
            word[70:64] = 7'($urandom);
            return word;
        end
        payload[31:0]  = $urandom;
        payload[63:32] = $urandom;
        slot = 0;
        for (int p = 1; p <= len; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                word[p-1] = payload[slot];
                slot++;
            end
        end
        // Setting the check bits for the syndrome of the data bits brings the
        // whole word back to a zero syndrome. Every check position needed for
        // that lies inside the codeword at each size.
        check = '0;
        for (int p = 1; p <= len; p++)
        begin
            if (word[p-1])
            begin
                check ^= 7'(p);
            end
        end
        for (int i = 0; i < 7; i++)
        begin
            if (check[i])
            begin
                word[(1 << i) - 1] = 1'b1;
            end
        end
        if (kind >= 3)
        begin
            slot = $urandom_range(1, len);
            word[slot-1] = ~word[slot-1];
        end
        if (kind == 7)
        begin
            slot = $urandom_range(1, len);
            word[slot-1] = ~word[slot-1];
        end
        if ($urandom_range(0, 1) == 1)
        begin
            for (int p = len + 1; p <= 71; p++)
            begin
                word[p-1] = 1'($urandom);
            end
        end
        return word;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("[%0t] %s: got %h, expected %h", $realtime, what, got, want);
        end
    endtask

    // The monitor. A codeword transfer pushes its expected result, and each
    // strobe is checked against the oldest one. The testbench copy of the
    // size select follows the configuration transfers. Outputs are sampled at
    // the clock edge, before anything driven at that edge can take effect.
    always @(posedge clk)
    begin
        hsd_pkg::result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                model_sel = cfg_data;
            end
            if (start && !busy)
            begin
                if (row_checked_by_hand)
                begin
                    pending_decodes.push_back(row_want);
                end
                else
                begin
                    pending_decodes.push_back(decode_codeword(model_sel, code_low,
                                                              code_high));
                end
            end
            if (done)
            begin
                if (pending_decodes.size() == 0)
                begin
                    flag_mismatch("result with no codeword pending", data_out, '0);
                end
                else
                begin
                    want = pending_decodes.pop_front();
                    if (data_out !== want.data)
                    begin
                        flag_mismatch("data_out", data_out, want.data);
                    end
                    if (syndrome !== want.syndrome)
                    begin
                        flag_mismatch("syndrome", 64'(syndrome), 64'(want.syndrome));
                    end
                    if (corrected !== want.corrected)
                    begin
                        flag_mismatch("corrected", 64'(corrected), 64'(want.corrected));
                    end
                    if (syndrome_out_of_range !== want.out_of_range)
                    begin
                        flag_mismatch("syndrome_out_of_range", 64'(syndrome_out_of_range),
                                      64'(want.out_of_range));
                    end
                end
            end
        end
    end

    // Offers one codeword and holds it until the block takes it. Start stays
    // high on return, so back-to-back codewords need no dead cycle.
    task automatic send_codeword(input logic [63:0] lo, input logic [6:0] hi,
                                 input bit by_hand, input hsd_pkg::result_t want);
        start               <= 1'b1;
        code_low            <= lo;
        code_high           <= hi;
        row_checked_by_hand <= by_hand;
        row_want            <= want;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    task automatic wait_for_results();
        while (pending_decodes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The size select is only changed while the block is empty. Start is
    // dropped first, and every outstanding result is allowed to arrive.
    task automatic switch_size(input hsd_pkg::size_t sel);
        start <= 1'b0;
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= sel;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [70:0]    word;
        hsd_pkg::size_t sel;
        int             burst_left;
        bit             no_gaps;
        rst_n               <= 1'b0;
        start               <= 1'b0;
        code_low            <= '0;
        code_high           <= '0;
        cfg_valid           <= 1'b0;
        cfg_data            <= '0;
        row_checked_by_hand <= 1'b0;
        row_want            <= NO_ERROR;
        model_sel            = '0;
        mismatch_count       = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows, grouped by size, with a configuration transfer at each
        // change of size.
        for (int i = 0; i < $size(directed_rows); i++)
        begin
            if (i == 0 || directed_rows[i].sel != directed_rows[i-1].sel)
            begin
                switch_size(directed_rows[i].sel);
            end
            send_codeword(directed_rows[i].lo, directed_rows[i].hi,
                          directed_rows[i].checked_by_hand, directed_rows[i].want);
        end

        // Random phases. The first eight walk every size select, including the
        // unused one, and the rest pick a size at random. The sender works in
        // bursts with random gaps, so gaps fall at every point of the decode
        // pipeline. Some phases run with no gaps at all.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            sel        = (ph < 8) ? hsd_pkg::size_t'(ph) : hsd_pkg::size_t'($urandom_range(0, 7));
            no_gaps    = ($urandom_range(0, 3) == 0);
            burst_left = 0;
            switch_size(sel);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (burst_left == 0)
                begin
                    if (!no_gaps)
                    begin
                        start <= 1'b0;
                        repeat ($urandom_range(1, 6)) @(posedge clk);
                    end
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                word = encode_random_word(sel);
                send_codeword(word[63:0], word[70:64], 1'b0, NO_ERROR);
            end
        end

        start <= 1'b0;
        wait_for_results();
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog. A correct run takes a small part of this time.
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/hsd_pkg.sv
rtl/hsd_correct.sv
rtl/hamming_sec_decoder.sv
tb/tb.sv
